// ===== rtl/assert_macros.svh =====
// Assertion helpers for the RTL file that carries checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, masked during reset
`define QMM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("qmm assertion failed: same-cycle implication");

// Next-cycle implication, masked during reset
`define QMM_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("qmm assertion failed: next-cycle implication");

`endif

// ===== rtl/qmm_pkg.sv =====
`default_nettype none

package qmm_pkg;

	// Fixed payload widths
	localparam int MOTOR_COUNT = 4;
	localparam int CMD_W       = 16;
	localparam int TICK_W      = 8;
	localparam int LEVEL_W     = 10;
	localparam int IDLE_W      = 7;
	localparam int CEIL_W      = 11;
	localparam int TIMER_W     = 16;
	localparam int MIX_W       = 19;

	// Configuration register widths and reset values
	localparam int IDLE_SET_W = 8;
	localparam int MAX_THR_W  = 7;
	localparam logic [IDLE_SET_W-1:0] IDLE_SET_RST = 8'd0;
	localparam logic [MAX_THR_W-1:0]  MAX_THR_RST  = 7'd80;
	localparam logic [IDLE_SET_W-1:0] IDLE_SET_MAX = 8'd10;

	// APB port geometry
	localparam int APB_AW = 3;
	localparam int APB_DW = 32;

	// Spin-up schedule in milliseconds
	localparam logic [TIMER_W-1:0] SPIN_STAGE1_MS = 16'd300;
	localparam logic [TIMER_W-1:0] SPIN_STAGE2_MS = 16'd600;
	localparam logic [TIMER_W-1:0] SPIN_STAGE3_MS = 16'd900;
	localparam logic [TIMER_W-1:0] SPIN_END_MS    = 16'd1200;

	// Output ceiling
	localparam logic [LEVEL_W-1:0] LEVEL_TOP = 10'd1000;

	// Motor slots, X frame
	localparam int M_FR = 0;
	localparam int M_FL = 1;
	localparam int M_RL = 2;
	localparam int M_RR = 3;

	// Register index, taken from paddr[2]
	typedef enum logic {
		REG_IDLE    = 1'b0,
		REG_MAX_THR = 1'b1
	} qmm_reg_idx_t;

	typedef struct packed {
		logic [IDLE_SET_W-1:0] idle_setting;
		logic [MAX_THR_W-1:0]  max_throttle_setting;
	} qmm_cfg_t;

	typedef logic [MOTOR_COUNT-1:0][LEVEL_W-1:0] qmm_levels_t;

	// Clamp with the lower bound tested first
	function automatic logic signed [MIX_W-1:0] clamp_lo_first(
		input logic signed [MIX_W-1:0] x,
		input logic signed [MIX_W-1:0] lo,
		input logic signed [MIX_W-1:0] hi
	);
		logic signed [MIX_W-1:0] r;
		if (x < lo) begin
			r = lo;
		end else if (x > hi) begin
			r = hi;
		end else begin
			r = x;
		end
		return r;
	endfunction

	// Multiply a narrow value by ten with two shifts and an add
	function automatic logic [CEIL_W-1:0] times_ten(input logic [MAX_THR_W-1:0] v);
		logic [CEIL_W-1:0] w;
		w = CEIL_W'(v);
		return (w << 3) + (w << 1);
	endfunction

endpackage

`default_nettype wire

// ===== rtl/qmm_if.sv =====
`default_nettype none

// Command channel: one control tick per transfer
interface qmm_cmd_if import qmm_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic                     armed;
	logic [TICK_W-1:0]        tick_ms;
	logic signed [CMD_W-1:0]  throttle_cmd;
	logic signed [CMD_W-1:0]  yaw_cmd;
	logic signed [CMD_W-1:0]  roll_cmd;
	logic signed [CMD_W-1:0]  pitch_cmd;

	modport source (
		output valid, armed, tick_ms, throttle_cmd, yaw_cmd, roll_cmd, pitch_cmd,
		input  ready
	);
	modport sink (
		input  valid, armed, tick_ms, throttle_cmd, yaw_cmd, roll_cmd, pitch_cmd,
		output ready
	);
endinterface

// Result channel: four motor levels and the spin-up flag
interface qmm_res_if import qmm_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [LEVEL_W-1:0] motor_front_right;
	logic [LEVEL_W-1:0] motor_front_left;
	logic [LEVEL_W-1:0] motor_rear_left;
	logic [LEVEL_W-1:0] motor_rear_right;
	logic               spun_up;

	modport source (
		output valid, motor_front_right, motor_front_left, motor_rear_left,
		       motor_rear_right, spun_up,
		input  ready
	);
	modport sink (
		input  valid, motor_front_right, motor_front_left, motor_rear_left,
		       motor_rear_right, spun_up,
		output ready
	);
endinterface

`default_nettype wire

// ===== rtl/qmm_regs.sv =====
`default_nettype none

module qmm_regs import qmm_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [APB_AW-1:0] paddr,
	input  wire logic [APB_DW-1:0] pwdata,
	output logic      [APB_DW-1:0] prdata,
	output logic                   pready,
	output qmm_cfg_t               cfg
);

	qmm_cfg_t     cfg_q;
	qmm_reg_idx_t idx;
	logic         wr_en;

	assign pready = 1'b1;
	assign idx    = qmm_reg_idx_t'(paddr[2]);
	assign wr_en  = psel && penable && pwrite && pready;
	assign cfg    = cfg_q;

	// Take writes in the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.idle_setting         <= IDLE_SET_RST;
			cfg_q.max_throttle_setting <= MAX_THR_RST;
		end else if (wr_en) begin
			case (idx)
				REG_IDLE:    cfg_q.idle_setting         <= pwdata[IDLE_SET_W-1:0];
				REG_MAX_THR: cfg_q.max_throttle_setting <= pwdata[MAX_THR_W-1:0];
				default: ;
			endcase
		end
	end

	// Read back the addressed register
	always_comb begin
		case (idx)
			REG_IDLE:    prdata = APB_DW'(cfg_q.idle_setting);
			REG_MAX_THR: prdata = APB_DW'(cfg_q.max_throttle_setting);
			default:     prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

// ===== rtl/qmm_mix.sv =====
`default_nettype none

module qmm_mix import qmm_pkg::*; (
	input  wire logic signed [CMD_W-1:0]  throttle_cmd,
	input  wire logic signed [CMD_W-1:0]  yaw_cmd,
	input  wire logic signed [CMD_W-1:0]  roll_cmd,
	input  wire logic signed [CMD_W-1:0]  pitch_cmd,
	input  wire logic        [IDLE_W-1:0] idle_level,
	input  wire logic        [CEIL_W-1:0] ceil_level,
	output qmm_levels_t                   levels
);

	localparam int EXT = MIX_W - CMD_W;

	logic signed [MIX_W-1:0] thr, yaw, rol, pit;
	logic signed [MIX_W-1:0] lo, ceil_w, top;
	logic signed [MIX_W-1:0] a, b;
	logic signed [MIX_W-1:0] mix [MOTOR_COUNT];

	// Widen everything so no sum wraps
	assign thr    = {{EXT{throttle_cmd[CMD_W-1]}}, throttle_cmd};
	assign yaw    = {{EXT{yaw_cmd[CMD_W-1]}}, yaw_cmd};
	assign rol    = {{EXT{roll_cmd[CMD_W-1]}}, roll_cmd};
	assign pit    = {{EXT{pitch_cmd[CMD_W-1]}}, pitch_cmd};
	assign lo     = $signed({{(MIX_W-IDLE_W){1'b0}}, idle_level});
	assign ceil_w = $signed({{(MIX_W-CEIL_W){1'b0}}, ceil_level});
	assign top    = $signed({{(MIX_W-LEVEL_W){1'b0}}, LEVEL_TOP});

	// Yaw split, clamped to idle..ceiling
	assign a = clamp_lo_first(thr - yaw, lo, ceil_w);
	assign b = clamp_lo_first(thr + yaw, lo, ceil_w);

	// X-frame roll and pitch terms
	assign mix[M_FR] = a + rol + pit;
	assign mix[M_FL] = b - rol + pit;
	assign mix[M_RL] = a - rol - pit;
	assign mix[M_RR] = b + rol - pit;

	// Final clamp to idle..full scale
	always_comb begin
		for (int i = 0; i < MOTOR_COUNT; i++) begin
			levels[i] = LEVEL_W'(clamp_lo_first(mix[i], lo, top));
		end
	end

endmodule

`default_nettype wire

// ===== rtl/quad_motor_mixer_with_spinup.sv =====
// A cmd transfer passes through the input stage and then the result stage to reach res.
// Throughput: one tick per cycle while res takes results; the mix and spin-up update finish in the result stage.
// A stalled res holds the result register; cmd is still taken while the input stage is empty.
// Reset (arst_n low, asynchronous): channels empty, spin-up flag, timer, motor levels
// cleared, idle_setting = 0, max_throttle_setting = 80.
`default_nettype none
`include "assert_macros.svh"

module quad_motor_mixer_with_spinup import qmm_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	qmm_cmd_if.sink                cmd,
	qmm_res_if.source              res,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [APB_AW-1:0] paddr,
	input  wire logic [APB_DW-1:0] pwdata,
	output logic      [APB_DW-1:0] prdata,
	output logic                   pready
);

	qmm_cfg_t cfg;

	// Input stage
	logic                     valid_s1;
	logic                     armed_s1;
	logic [TICK_W-1:0]        tick_s1;
	logic signed [CMD_W-1:0]  thr_s1, yaw_s1, rol_s1, pit_s1;

	// Result stage, which is also the block state
	logic                     valid_s2;
	logic                     spinup_done_q;
	logic [TIMER_W-1:0]       spinup_timer_q;
	qmm_levels_t              motor_level_q;

	logic                     adv;
	logic                     take;
	logic [IDLE_SET_W-1:0]    idle_sel;
	logic [IDLE_W-1:0]        idle_lvl;
	logic [CEIL_W-1:0]        ceil_lvl;
	logic [TIMER_W-1:0]       timer_sum;
	logic                     done_n;
	logic [TIMER_W-1:0]       timer_n;
	qmm_levels_t              level_n;
	qmm_levels_t              mix_lvl;

	qmm_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Handshake: result stage moves when empty or drained
	assign adv       = !valid_s2 || res.ready;
	assign take      = adv && valid_s1;
	assign cmd.ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.ready) begin
			valid_s1 <= cmd.valid;
		end
	end

	// Capture the tick payload
	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			armed_s1 <= cmd.armed;
			tick_s1  <= cmd.tick_ms;
			thr_s1   <= cmd.throttle_cmd;
			yaw_s1   <= cmd.yaw_cmd;
			rol_s1   <= cmd.roll_cmd;
			pit_s1   <= cmd.pitch_cmd;
		end
	end

	// Idle level (setting capped at 10) and throttle ceiling, both times ten
	assign idle_sel = (cfg.idle_setting > IDLE_SET_MAX) ? IDLE_SET_MAX : cfg.idle_setting;
	assign idle_lvl = IDLE_W'(times_ten(idle_sel[MAX_THR_W-1:0]));
	assign ceil_lvl = times_ten(cfg.max_throttle_setting);

	qmm_mix u_mix (
		.throttle_cmd (thr_s1),
		.yaw_cmd      (yaw_s1),
		.roll_cmd     (rol_s1),
		.pitch_cmd    (pit_s1),
		.idle_level   (idle_lvl),
		.ceil_level   (ceil_lvl),
		.levels       (mix_lvl)
	);

	assign timer_sum = spinup_timer_q + TIMER_W'(tick_s1);

	// Spin-up sequence, mixer select and clear on disarm
	always_comb begin
		done_n  = spinup_done_q;
		timer_n = spinup_timer_q;
		level_n = motor_level_q;
		if (armed_s1) begin
			if (!spinup_done_q) begin
				timer_n = timer_sum;
				if (timer_sum < SPIN_STAGE1_MS) begin
					level_n[M_FR] = LEVEL_W'(idle_lvl);
				end else if (timer_sum < SPIN_STAGE2_MS) begin
					level_n[M_FL] = LEVEL_W'(idle_lvl);
				end else if (timer_sum < SPIN_STAGE3_MS) begin
					level_n[M_RL] = LEVEL_W'(idle_lvl);
				end else if (timer_sum < SPIN_END_MS) begin
					level_n[M_RR] = LEVEL_W'(idle_lvl);
				end else begin
					done_n  = 1'b1;
					timer_n = '0;
				end
			end
			if (done_n) begin
				level_n = mix_lvl;
			end
		end else begin
			done_n  = 1'b0;
			level_n = '0;
		end
	end

	// Advance state and result register together
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2       <= 1'b0;
			spinup_done_q  <= 1'b0;
			spinup_timer_q <= '0;
			motor_level_q  <= '0;
		end else begin
			if (adv) begin
				valid_s2 <= valid_s1;
			end
			if (take) begin
				spinup_done_q  <= done_n;
				spinup_timer_q <= timer_n;
				motor_level_q  <= level_n;
			end
		end
	end

	assign res.valid             = valid_s2;
	assign res.motor_front_right = motor_level_q[M_FR];
	assign res.motor_front_left  = motor_level_q[M_FL];
	assign res.motor_rear_left   = motor_level_q[M_RL];
	assign res.motor_rear_right  = motor_level_q[M_RR];
	assign res.spun_up           = spinup_done_q;

	// Checks
	`QMM_ASSERT_IMP(a_timer_clear_when_done, clk, arst_n, spinup_done_q, spinup_timer_q == '0)
	`QMM_ASSERT_IMP(a_levels_in_range, clk, arst_n, valid_s2, (motor_level_q[M_FR] <= LEVEL_TOP) && (motor_level_q[M_FL] <= LEVEL_TOP) && (motor_level_q[M_RL] <= LEVEL_TOP) && (motor_level_q[M_RR] <= LEVEL_TOP))
	`QMM_ASSERT_NXT(a_disarm_zeroes, clk, arst_n, take && !armed_s1, (motor_level_q == '0) && !spinup_done_q && valid_s2)
	`QMM_ASSERT_NXT(a_hold_state_on_stall, clk, arst_n, !take, $stable(spinup_timer_q) && $stable(spinup_done_q))

endmodule

`default_nettype wire
